@@ rtl/core/salsa_pkg.sv @@
// Shared types, constants and helper functions for the Salsa20 keystream XOR block.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package salsa_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 16;
    localparam int CFG_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int CTR_WORD  = 8;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [3:0]           t_widx;
    typedef logic [1:0]           t_step;
    typedef t_word [NUM_WORDS-1:0] t_block;

    // Command from the top level to the block generator.
    typedef struct packed {
        logic  start;
        t_word ctr;
    } t_core_cmd;

    // Status from the block generator to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    // Word indexes of each quarter round: [row round][lane][role a, b, c, d].
    localparam t_widx Q_IDX [2][4][4] = '{
        '{ '{4'd0,  4'd4,  4'd8,  4'd12},
           '{4'd5,  4'd9,  4'd13, 4'd1 },
           '{4'd10, 4'd14, 4'd2,  4'd6 },
           '{4'd15, 4'd3,  4'd7,  4'd11} },
        '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
           '{4'd5,  4'd6,  4'd7,  4'd4 },
           '{4'd10, 4'd11, 4'd8,  4'd9 },
           '{4'd15, 4'd12, 4'd13, 4'd14} }
    };

    // Word index of one role of one quarter round.
    function automatic t_widx qidx(logic row, logic [1:0] lane, t_step role);
        return Q_IDX[row][lane][role];
    endfunction

    // Left rotation used by each of the four quarter-round steps (7, 9, 13, 18).
    function automatic t_word rotl_step(t_word v, t_step s);
        t_word r;
        unique case (s)
            2'd0: r = {v[24:0], v[31:25]};
            2'd1: r = {v[22:0], v[31:23]};
            2'd2: r = {v[18:0], v[31:19]};
            2'd3: r = {v[13:0], v[31:14]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/salsa_round_unit.sv @@
// Shared datapath: one quarter-round step on all four lanes of a round at once.
// Depends on salsa_pkg for the index table and rotation helper.
module salsa_round_unit (
    input  salsa_pkg::t_block i_w,
    input  logic              i_row,
    input  salsa_pkg::t_step  i_step,
    output salsa_pkg::t_block o_w
);

    // Each lane adds two words, rotates the sum and folds it into a third word.
    // The four lanes touch disjoint words, so they update independently.
    always_comb begin
        salsa_pkg::t_word sum;
        salsa_pkg::t_widx ia;
        salsa_pkg::t_widx ib;
        salsa_pkg::t_widx it;
        o_w = i_w;
        for (int l = 0; l < 4; l++) begin
            ia = salsa_pkg::qidx(i_row, 2'(l), i_step);
            ib = salsa_pkg::qidx(i_row, 2'(l), i_step - 2'd1);
            it = salsa_pkg::qidx(i_row, 2'(l), i_step + 2'd1);
            sum = i_w[ia] + i_w[ib];
            o_w[it] = i_w[it] ^ salsa_pkg::rotl_step(sum, i_step);
        end
    end

endmodule

@@ rtl/core/salsa_core.sv @@
// Block generator: working state registers and the sequencer that drives the round unit.
// Depends on salsa_pkg and salsa_round_unit.
module salsa_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  salsa_pkg::t_core_cmd  i_cmd,
    input  salsa_pkg::t_block     i_tmpl,
    output salsa_pkg::t_core_stat o_stat,
    output salsa_pkg::t_block     o_keystream
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W  = $clog2(ROUNDS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_FINAL = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [RND_W-1:0]   r_rnd, n_rnd;
    salsa_pkg::t_step   r_step, n_step;
    salsa_pkg::t_word   r_ctr, n_ctr;
    salsa_pkg::t_block  r_w, n_w;
    salsa_pkg::t_block  v_in;
    salsa_pkg::t_block  v_step;
    logic               v_last;

    // Input state of the block being made: template with the counter as word 8.
    always_comb begin
        v_in = i_tmpl;
        v_in[salsa_pkg::CTR_WORD] = r_ctr;
    end

    salsa_round_unit u_round (
        .i_w    (r_w),
        .i_row  (r_rnd[0]),
        .i_step (r_step),
        .o_w    (v_step)
    );

    assign v_last = (r_rnd == RND_W'(ROUNDS - 1)) && (r_step == 2'd3);

    // Sequencer: load, four steps per round, feed-forward add, hand off.
    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_step  = r_step;
        n_ctr   = r_ctr;
        n_w     = r_w;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_state = S_ROUND;
                    n_rnd   = '0;
                    n_step  = '0;
                    n_ctr   = i_cmd.ctr;
                    n_w     = i_tmpl;
                    n_w[salsa_pkg::CTR_WORD] = i_cmd.ctr;
                end
            end
            S_ROUND: begin
                n_w    = v_step;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_rnd = r_rnd + RND_W'(1);
                end
                if (v_last) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                for (int i = 0; i < salsa_pkg::NUM_WORDS; i++) begin
                    n_w[i] = r_w[i] + v_in[i];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_step  <= n_step;
        end
    end

    // Working state and counter copy.
    always_ff @(posedge i_clk) begin
        r_ctr <= n_ctr;
        r_w   <= n_w;
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_keystream  = r_w;

endmodule

@@ rtl/core/salsa20_keystream_xor.sv @@
// Top level of the Salsa20 keystream XOR block: template registers, word handshakes,
// block counter and word position. Depends on salsa_pkg and salsa_core.
//
//   Channel  Direction  Signals                                   Moves
//   in       input      i_in_valid / o_in_ready                   i_data_word, i_first_word
//   out      output     o_out_valid / i_out_ready                 o_result_word
//   cfg      input      i_cfg_we, i_cfg_idx, i_cfg_data           one 64-bit template register
//
// A word that opens a block (position zero or first_word set) has its result registered
// after the load at the accepting edge, four steps of the shared quarter-round unit per
// round, one feed-forward add and one handoff. The other fifteen words of a block are XORed
// with the stored keystream and registered at their accepting edge. Reset is synchronous
// and clears the template, counter and position; a stalled output holds the input off.
module salsa20_keystream_xor #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [31:0]                       i_data_word,
    input  logic                              i_first_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [31:0]                       o_result_word,
    input  logic                              i_cfg_we,
    input  logic [salsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salsa_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [salsa_pkg::CFG_W-1:0] r_cfg [salsa_pkg::CFG_REGS];
    logic [3:0]                  r_pos, n_pos;
    salsa_pkg::t_word            r_ctr, n_ctr;
    logic                        r_pend, n_pend;
    salsa_pkg::t_word            r_data, n_data;
    salsa_pkg::t_word            r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    salsa_pkg::t_block           v_tmpl;
    salsa_pkg::t_block           v_ks;
    salsa_pkg::t_core_cmd        v_cmd;
    salsa_pkg::t_core_stat       v_stat;
    logic                        v_accept;
    logic [3:0]                  v_pos;
    salsa_pkg::t_word            v_ctr;

    // Unpack the template registers into sixteen words.
    always_comb begin
        for (int i = 0; i < salsa_pkg::CFG_REGS; i++) begin
            v_tmpl[2*i]   = r_cfg[i][31:0];
            v_tmpl[2*i+1] = r_cfg[i][63:32];
        end
    end

    // Template register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < salsa_pkg::CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < salsa_pkg::CFG_IDX_W'(salsa_pkg::CFG_REGS))) begin
            r_cfg[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    salsa_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (v_cmd),
        .i_tmpl      (v_tmpl),
        .o_stat      (v_stat),
        .o_keystream (v_ks)
    );

    // A new word is taken when no block is in progress and the output slot frees up.
    assign o_in_ready = !r_pend && !v_stat.busy && (!r_out_valid || i_out_ready);
    assign v_accept   = i_in_valid && o_in_ready;
    assign v_pos      = i_first_word ? 4'd0 : r_pos;
    assign v_ctr      = i_first_word ? '0 : r_ctr;

    assign v_cmd.start = v_accept && (v_pos == 4'd0);
    assign v_cmd.ctr   = v_ctr;

    // Word flow: start a block (word XORed when done) or XOR at once with stored keystream.
    always_comb begin
        n_pos       = r_pos;
        n_ctr       = r_ctr;
        n_pend      = r_pend;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (v_accept) begin
            n_pos = v_pos + 4'd1;
            if (v_pos == 4'd0) begin
                n_ctr  = v_ctr + 32'd1;
                n_pend = 1'b1;
                n_data = i_data_word;
            end else begin
                n_out       = i_data_word ^ v_ks[v_pos];
                n_out_valid = 1'b1;
            end
        end
        if (r_pend && v_stat.done) begin
            n_pend      = 1'b0;
            n_out       = r_data ^ v_ks[0];
            n_out_valid = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_ctr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_ctr       <= n_ctr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_out;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for salsa20_keystream_xor: a Salsa20 keystream predictor with a
// scoreboard checks every result word. Depends on salsa_pkg and the RTL of the block.
module tb_top;

    localparam int N_DOUBLE_ROUNDS = 10;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 64;
    localparam int LONG_HOLD       = 300;

    // Word patterns that drive the data bits to their extremes.
    localparam salsa_pkg::t_word EDGE_WORDS [6] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h8000_0000, 32'h0000_0001
    };

    // Keystream predictor and store of expected result words.
    class keystream_scoreboard;
        logic [salsa_pkg::CFG_W-1:0] template_regs [salsa_pkg::CFG_REGS];
        salsa_pkg::t_word            keystream [salsa_pkg::NUM_WORDS];
        salsa_pkg::t_word            mix [salsa_pkg::NUM_WORDS];
        logic [3:0]                  position;
        salsa_pkg::t_word            block_ctr;
        salsa_pkg::t_word            expected_words [$];
        int                          errors;
        int                          checked;

        function new();
            foreach (template_regs[i]) template_regs[i] = '0;
            foreach (keystream[i]) keystream[i] = '0;
            position  = '0;
            block_ctr = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        // Writes to indexes past the last register are dropped by the block.
        function void write_template(logic [salsa_pkg::CFG_IDX_W-1:0] idx,
                                     logic [salsa_pkg::CFG_W-1:0] value);
            if (idx < salsa_pkg::CFG_REGS) template_regs[idx[2:0]] = value;
        endfunction

        function salsa_pkg::t_word rotate_left(salsa_pkg::t_word v, int unsigned n);
            return (v << n) | (v >> (salsa_pkg::WORD_W - n));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[b] ^= rotate_left(mix[a] + mix[d], 7);
            mix[c] ^= rotate_left(mix[b] + mix[a], 9);
            mix[d] ^= rotate_left(mix[c] + mix[b], 13);
            mix[a] ^= rotate_left(mix[d] + mix[c], 18);
        endfunction

        // Builds the next keystream block from the template and the block counter.
        function void refill_keystream();
            salsa_pkg::t_word in_words [salsa_pkg::NUM_WORDS];
            for (int i = 0; i < salsa_pkg::CFG_REGS; i++) begin
                in_words[2*i]   = template_regs[i][31:0];
                in_words[2*i+1] = template_regs[i][63:32];
            end
            in_words[salsa_pkg::CTR_WORD] = block_ctr;
            mix = in_words;
            for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
                quarter(0, 4, 8, 12);
                quarter(5, 9, 13, 1);
                quarter(10, 14, 2, 6);
                quarter(15, 3, 7, 11);
                quarter(0, 1, 2, 3);
                quarter(5, 6, 7, 4);
                quarter(10, 11, 8, 9);
                quarter(15, 12, 13, 14);
            end
            for (int i = 0; i < salsa_pkg::NUM_WORDS; i++) keystream[i] = mix[i] + in_words[i];
            block_ctr = block_ctr + 32'd1;
        endfunction

        // Called for every word accepted on the input channel.
        function void note_word(salsa_pkg::t_word data, logic first);
            if (first) begin
                block_ctr = '0;
                position  = '0;
            end
            if (position == 4'd0) refill_keystream();
            expected_words.push_back(data ^ keystream[position]);
            position = position + 4'd1;
        endfunction

        // Called for every word accepted on the output channel.
        function void check_word(salsa_pkg::t_word actual);
            salsa_pkg::t_word want;
            if (expected_words.size() == 0) begin
                $error("result_word: got %h with no word expected", actual);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            checked++;
            if (want !== actual) begin
                $error("result_word mismatch: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [31:0]                     i_data_word;
    logic                            i_first_word;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [31:0]                     o_result_word;
    logic                            i_cfg_we;
    logic [salsa_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [salsa_pkg::CFG_W-1:0]     i_cfg_data;

    keystream_scoreboard sb = new();
    bit quiet_phase    = 1'b0;
    bit long_hold_req  = 1'b0;

    salsa20_keystream_xor #(
        .DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_first_word (i_first_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_word(o_result_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Output side: random stalls, one long hold-off on request, none in a quiet phase.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (quiet_phase) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 8);
            end
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_word(o_result_word);
    end

    // Offers one word and waits until the block takes it; valid stays high afterwards.
    task automatic send_word(input salsa_pkg::t_word data, input logic first);
        i_in_valid   <= 1'b1;
        i_data_word  <= data;
        i_first_word <= first;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(data, first);
    endtask

    // Random gap on the input side.
    task automatic maybe_pause();
        int n;
        if (!quiet_phase && $urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stops offering words until every expected result word has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the write enable after the last one.
    task automatic cfg_write(input logic [salsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [salsa_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_template(idx, value);
    endtask

    function automatic logic [salsa_pkg::CFG_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Main sequence: reset, directed words, then random phases.
    initial begin
        int phase_sent;
        int msg_len;
        int n_writes;
        logic first;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_word  <= '0;
        i_first_word <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Template still at reset: the first word must open a block without the flag.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        drain();

        // All-ones template, plus writes to indexes that do not exist.
        for (int i = 0; i < salsa_pkg::CFG_REGS; i++) begin
            cfg_write(salsa_pkg::CFG_IDX_W'(i), '1);
        end
        cfg_write(4'd8, {$urandom(), $urandom()});
        cfg_write(4'd15, {$urandom(), $urandom()});
        i_cfg_we <= 1'b0;

        // Restart, then run across a block boundary so the counter steps and the position wraps.
        for (int k = 0; k < 17; k++) begin
            send_word(EDGE_WORDS[k % 6], k == 0);
            maybe_pause();
        end
        drain();

        // Standard constants with a key, written in the middle of a block.
        cfg_write(4'd0, {32'h0302_0100, 32'h6170_7865});
        cfg_write(4'd1, {32'h0B0A_0908, 32'h0706_0504});
        cfg_write(4'd2, {32'h3320_646E, 32'h0F0E_0D0C});
        cfg_write(4'd3, {32'h6574_6E4F, 32'h4E6F_6E63});
        cfg_write(4'd4, {32'hDEAD_BEEF, 32'h1234_5678});
        cfg_write(4'd5, {32'h1312_1110, 32'h7962_2D32});
        cfg_write(4'd6, {32'h1B1A_1918, 32'h1716_1514});
        cfg_write(4'd7, {32'h6B20_6574, 32'h1F1E_1D1C});
        i_cfg_we <= 1'b0;

        // The stored keystream carries on; the new template shows after the restart.
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word($urandom(), 1'b0);
        send_word($urandom(), 1'b1);
        drain();

        // Random phases: mostly messages that start with the flag, some broken or noisy.
        for (int p = 0; p < PHASES; p++) begin
            quiet_phase = (p == 5);
            n_writes = $urandom_range(1, 4);
            for (int w = 0; w < n_writes; w++) begin
                cfg_write(salsa_pkg::CFG_IDX_W'($urandom_range(0, 15)), pick_reg_value());
            end
            i_cfg_we <= 1'b0;
            if (p == 2) long_hold_req = 1'b1;

            phase_sent = 0;
            while (phase_sent < WORDS_PER_PHASE) begin
                msg_len = $urandom_range(1, 48);
                for (int k = 0; k < msg_len && phase_sent < WORDS_PER_PHASE; k++) begin
                    if (k == 0) begin
                        first = ($urandom_range(0, 99) < 85);
                    end else begin
                        first = ($urandom_range(0, 39) == 0);
                    end
                    send_word($urandom(), first);
                    phase_sent++;
                    maybe_pause();
                end
            end
            drain();
        end
        quiet_phase = 1'b0;

        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
